@@ hdl/vmc_pkg.sv @@
// vmc_pkg: widths and types shared by the vector magnitude clamp.
// No dependencies.
package vmc_pkg;
  localparam int CompW  = 31;          // signed component width
  localparam int CapW   = 30;          // cap width
  localparam int RootW  = 31;          // isqrt of 63-bit sum
  localparam int SumW   = 63;          // sum of three squares <= 3*2^60
  localparam int ProdW  = 60;          // |comp| * cap < 2^60
  localparam int QuoW   = 30;          // quotient < |comp| <= 2^30

  // one item as it travels through the cells
  typedef struct packed {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
    logic [CapW-1:0]         cap;
  } vec_t;
endpackage

@@ hdl/vmc_sqrt_cell.sv @@
// vmc_sqrt_cell: one digit step of the bit-pair integer square root.
// Depends on vmc_pkg.
module vmc_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vmc_pkg::SumW-1:0]  rem_in,
  input  logic [vmc_pkg::RootW-1:0] root_in,
  input  vmc_pkg::vec_t           vec_in,
  output logic [vmc_pkg::SumW-1:0]  rem,
  output logic [vmc_pkg::RootW-1:0] root,
  output vmc_pkg::vec_t           vec
);
  import vmc_pkg::*;

  // partial root so far holds Step bits; trial = (root<<2|1) << shift
  localparam int Sh = 2 * (RootW - 1 - Step);
  logic [SumW+1:0] trial;
  logic [SumW+1:0] rem_w;

  always_comb begin
    trial = ({{(SumW+2-RootW){1'b0}}, root_in} << 2 | (SumW+2)'(1)) << Sh;
    rem_w = {2'b00, rem_in};
  end

  // each cell resolves one root bit
  always_ff @(posedge clk) begin
    if (en) begin
      vec <= vec_in;
      if (rem_w >= trial) begin
        rem  <= SumW'(rem_w - trial);
        root <= {root_in[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_in;
        root <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ hdl/vmc_div_cell.sv @@
// vmc_div_cell: one restoring-division step for all three components.
// Depends on vmc_pkg.
module vmc_div_cell #(
  parameter int Step = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vmc_pkg::RootW-1:0] mag,
  input  logic [vmc_pkg::ProdW-1:0] num_in [3],
  input  logic [vmc_pkg::RootW:0]   prem_in [3],
  input  logic [vmc_pkg::QuoW-1:0]  quo_in [3],
  output logic [vmc_pkg::ProdW-1:0] num [3],
  output logic [vmc_pkg::RootW:0]   prem [3],
  output logic [vmc_pkg::QuoW-1:0]  quo [3]
);
  import vmc_pkg::*;

  // numerator bit brought down in this step
  localparam int Bit = ProdW - 1 - Step;

  logic [RootW+1:0] t [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i] = {prem_in[i], num_in[i][Bit]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= num_in[i];
        if (t[i] >= {1'b0, 1'b0, mag}) begin
          prem[i] <= (RootW+1)'(t[i] - {2'b00, mag});
          quo[i]  <= {quo_in[i][QuoW-2:0], 1'b1};
        end else begin
          prem[i] <= (RootW+1)'(t[i]);
          quo[i]  <= {quo_in[i][QuoW-2:0], 1'b0};
        end
      end
    end
  end
endmodule

@@ hdl/vector_magnitude_clamp.sv @@
// vector_magnitude_clamp: top level; square-root and divider cell chains.
// Depends on vmc_pkg, vmc_sqrt_cell, vmc_div_cell.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   s_axis_tvalid/tready   tdata: vel_x, vel_y, vel_z, max_speed
// m_axis   out  m_axis_tvalid/tready   tdata: out_x, out_y, out_z, was_clamped
//
// One item per cycle while the chain advances; pipeline: 2 input registers, 31 root cells, 60 divider cells, 1 output.
// The whole chain advances when the output register is free or drained.
// Reset clears valid bits only; payload registers are not reset.
module vector_magnitude_clamp (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // vel_x[30:0], vel_y[61:31], vel_z[92:62],
                                      // max_speed[122:93], zeros
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata   // out_x[30:0], out_y[61:31], out_z[92:62],
                                      // was_clamped[93], zeros
);
  import vmc_pkg::*;

  localparam int NSq  = RootW;
  localparam int NDiv = ProdW;
  localparam int Lat  = 3 + NSq + NDiv;

  logic adv;
  logic [Lat-1:0] vld;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  // stage 0: register input; absolute values follow, squares are registered in stage 1
  vec_t v0;
  logic [CompW-1:0] ax, ay, az;
  logic [2*CompW-1:0] sx, sy, sz;
  always_ff @(posedge clk) begin
    if (adv) begin
      v0.x   <= s_axis_tdata[30:0];
      v0.y   <= s_axis_tdata[61:31];
      v0.z   <= s_axis_tdata[92:62];
      v0.cap <= s_axis_tdata[122:93];
    end
  end
  assign ax = v0.x[CompW-1] ? CompW'(-v0.x) : v0.x;
  assign ay = v0.y[CompW-1] ? CompW'(-v0.y) : v0.y;
  assign az = v0.z[CompW-1] ? CompW'(-v0.z) : v0.z;

  vec_t v1;
  logic [SumW-1:0] sum1;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= ax * ax; sy <= ay * ay; sz <= az * az;
      v1 <= v0;
    end
  end
  // stage 1 output feeds root chain
  logic [SumW-1:0] rem_c [NSq+1];
  logic [RootW-1:0] root_c [NSq+1];
  vec_t vec_c [NSq+1];
  assign sum1 = SumW'(sx) + SumW'(sy) + SumW'(sz);
  assign rem_c[0] = sum1;
  assign root_c[0] = '0;
  assign vec_c[0] = v1;

  for (genvar g = 0; g < NSq; g++) begin : g_sq
    vmc_sqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem_c[g]), .root_in(root_c[g]), .vec_in(vec_c[g]),
      .rem(rem_c[g+1]), .root(root_c[g+1]), .vec(vec_c[g+1])
    );
  end

  // products |comp| * cap, entering the divider chain
  vec_t vs;
  logic [RootW-1:0] mag;
  logic clamp;
  assign vs = vec_c[NSq];
  assign mag = root_c[NSq];
  assign clamp = {1'b0, vs.cap} < mag;

  logic [CompW-1:0] bx, by, bz;
  assign bx = vs.x[CompW-1] ? CompW'(-vs.x) : vs.x;
  assign by = vs.y[CompW-1] ? CompW'(-vs.y) : vs.y;
  assign bz = vs.z[CompW-1] ? CompW'(-vs.z) : vs.z;

  logic [ProdW-1:0] num_c [NDiv+1][3];
  logic [RootW:0] prem_c [NDiv+1][3];
  logic [QuoW-1:0] quo_c [NDiv+1][3];
  logic [RootW-1:0] mag_d [NDiv+1];
  vec_t vec_d [NDiv+1];
  logic clamp_d [NDiv+1];

  assign num_c[0][0] = ProdW'(bx[CapW-1:0] * vs.cap) | (bx[CapW] ? ProdW'(vs.cap) << CapW : '0);
  assign num_c[0][1] = ProdW'(by[CapW-1:0] * vs.cap) | (by[CapW] ? ProdW'(vs.cap) << CapW : '0);
  assign num_c[0][2] = ProdW'(bz[CapW-1:0] * vs.cap) | (bz[CapW] ? ProdW'(vs.cap) << CapW : '0);
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign prem_c[0][i] = '0;
    assign quo_c[0][i]  = '0;
  end
  assign mag_d[0] = clamp ? mag : RootW'(1);
  assign vec_d[0] = vs;
  assign clamp_d[0] = clamp;

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    vmc_div_cell #(.Step(g)) u_cell (
      .clk(clk), .en(adv), .mag(mag_d[g]),
      .num_in(num_c[g]), .prem_in(prem_c[g]), .quo_in(quo_c[g]),
      .num(num_c[g+1]), .prem(prem_c[g+1]), .quo(quo_c[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        mag_d[g+1]   <= mag_d[g];
        vec_d[g+1]   <= vec_d[g];
        clamp_d[g+1] <= clamp_d[g];
      end
    end
  end

  // output register: restore sign, choose scaled or original
  vec_t vo;
  logic co;
  logic [CompW-1:0] qx, qy, qz, rx, ry, rz;
  assign vo = vec_d[NDiv];
  assign co = clamp_d[NDiv];
  assign qx = {1'b0, quo_c[NDiv][0]};
  assign qy = {1'b0, quo_c[NDiv][1]};
  assign qz = {1'b0, quo_c[NDiv][2]};
  assign rx = !co ? vo.x : (vo.x[CompW-1] ? CompW'(-qx) : qx);
  assign ry = !co ? vo.y : (vo.y[CompW-1] ? CompW'(-qy) : qy);
  assign rz = !co ? vo.z : (vo.z[CompW-1] ? CompW'(-qz) : qz);

  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {2'b00, co, rz, ry, rx};
  end
  assign m_axis_tvalid = vld[Lat-1];

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  // valid bits freeze while the chain is stalled
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready not tied to output register");
endmodule
